@@ src/owm_pkg.sv @@
// package: shared types, constants and register indexes of the 1-wire bus master
`timescale 1ns / 1ps
`default_nettype none
package owm_pkg;

  localparam int unsigned TimerWidth   = 10;
  localparam int unsigned NumRegs      = 8;
  localparam int unsigned RegIdxWidth  = 3;
  localparam int unsigned CfgIdxWidth  = 4;
  localparam int unsigned CfgDataWidth = 10;

  // register indexes
  localparam logic [RegIdxWidth-1:0] RegResetLow     = 3'd0;
  localparam logic [RegIdxWidth-1:0] RegPresenceWait = 3'd1;
  localparam logic [RegIdxWidth-1:0] RegResetTail    = 3'd2;
  localparam logic [RegIdxWidth-1:0] RegWriteLow     = 3'd3;
  localparam logic [RegIdxWidth-1:0] RegWriteHold    = 3'd4;
  localparam logic [RegIdxWidth-1:0] RegReadLow      = 3'd5;
  localparam logic [RegIdxWidth-1:0] RegReadSample   = 3'd6;
  localparam logic [RegIdxWidth-1:0] RegReadTail     = 3'd7;

  // function codes of an input beat
  localparam logic [1:0] FuncTick  = 2'd0;
  localparam logic [1:0] FuncReset = 2'd1;
  localparam logic [1:0] FuncWrite = 2'd2;
  localparam logic [1:0] FuncRead  = 2'd3;

  typedef logic [NumRegs-1:0][CfgDataWidth-1:0] cfg_bank_t;

  localparam cfg_bank_t RegResetVals = {
    10'd65, 10'd4, 10'd6, 10'd45, 10'd15, 10'd440, 10'd80, 10'd500
  };

  typedef struct packed {
    logic [1:0] func;
    logic       line_level;
    logic [7:0] write_byte;
  } in_item_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       device_present;
    logic [7:0] read_byte;
  } out_item_t;

endpackage
`default_nettype wire

@@ src/owm_if.sv @@
// interfaces: input, result and configuration channels
`timescale 1ns / 1ps
`default_nettype none
interface owm_in_if;
  logic               valid;
  logic               ready;
  owm_pkg::in_item_t  item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface owm_out_if;
  logic               valid;
  logic               ready;
  owm_pkg::out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface owm_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [owm_pkg::CfgIdxWidth-1:0]     index;
  logic [owm_pkg::CfgDataWidth-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ src/owm_cfg_regs.sv @@
// configuration register bank holding the phase durations
`timescale 1ns / 1ps
`default_nettype none
module owm_cfg_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  owm_cfg_if.sink            cfg_i,
  output owm_pkg::cfg_bank_t regs_o
);

  owm_pkg::cfg_bank_t regs_q;
  logic               wr_en;

  assign cfg_i.ready = 1'b1;
  assign wr_en = cfg_i.valid && cfg_i.ready &&
                 (cfg_i.index < owm_pkg::CfgIdxWidth'(owm_pkg::NumRegs));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= owm_pkg::RegResetVals;
    end else if (wr_en) begin
      regs_q[cfg_i.index[owm_pkg::RegIdxWidth-1:0]] <= cfg_i.data;
    end
  end

  assign regs_o = regs_q;

endmodule
`default_nettype wire

@@ src/owm_core.sv @@
// bus sequencer: phase, slot timer, shifter and result computation
`timescale 1ns / 1ps
`default_nettype none
module owm_core #(
  parameter int unsigned TimerWidth = owm_pkg::TimerWidth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  owm_pkg::in_item_t  item_i,
  input  owm_pkg::cfg_bank_t regs_i,
  output owm_pkg::out_item_t res_o
);

  localparam logic [3:0] PhIdle    = 4'd0;
  localparam logic [3:0] PhRstLow  = 4'd1;
  localparam logic [3:0] PhRstWait = 4'd2;
  localparam logic [3:0] PhRstTail = 4'd3;
  localparam logic [3:0] PhWrLow   = 4'd4;
  localparam logic [3:0] PhWrHold  = 4'd5;
  localparam logic [3:0] PhRdLow   = 4'd6;
  localparam logic [3:0] PhRdSamp  = 4'd7;
  localparam logic [3:0] PhRdTail  = 4'd8;

  localparam int unsigned CmpWidth =
    (TimerWidth > owm_pkg::CfgDataWidth) ? TimerWidth : owm_pkg::CfgDataWidth;
  localparam logic [TimerWidth-1:0] TimerMax = '1;

  logic [3:0]            phase_q, phase_d, phase_cur;
  logic [TimerWidth-1:0] slot_timer_q, slot_timer_d;
  logic [2:0]            bit_count_q, bit_count_d;
  logic [7:0]            shift_byte_q, shift_byte_d;
  logic                  presence_q, presence_d;
  logic [7:0]            received_q, received_d;

  logic                        load_en;
  logic [owm_pkg::RegIdxWidth-1:0] load_idx;
  logic [CmpWidth-1:0]         dur_ext;
  logic [TimerWidth-1:0]       dur_sat;
  logic                        done;
  logic                        drive;

  // saturated duration of the register a phase loads
  always_comb begin
    dur_ext = CmpWidth'(regs_i[load_idx]);
    if (dur_ext == '0) begin
      dur_sat = TimerWidth'(1);
    end else if (dur_ext > CmpWidth'(TimerMax)) begin
      dur_sat = TimerMax;
    end else begin
      dur_sat = dur_ext[TimerWidth-1:0];
    end
  end

  always_comb begin
    phase_cur    = (phase_q > PhRdTail) ? PhIdle : phase_q;
    phase_d      = phase_cur;
    slot_timer_d = slot_timer_q;
    bit_count_d  = bit_count_q;
    shift_byte_d = shift_byte_q;
    presence_d   = presence_q;
    received_d   = received_q;
    load_en      = 1'b0;
    load_idx     = owm_pkg::RegResetLow;
    done         = 1'b0;

    if (item_i.func != owm_pkg::FuncTick) begin
      if (phase_cur == PhIdle) begin
        bit_count_d = '0;
        load_en     = 1'b1;
        case (item_i.func)
          owm_pkg::FuncReset: begin
            phase_d  = PhRstLow;
            load_idx = owm_pkg::RegResetLow;
          end
          owm_pkg::FuncWrite: begin
            phase_d      = PhWrLow;
            load_idx     = owm_pkg::RegWriteLow;
            shift_byte_d = item_i.write_byte;
          end
          default: begin
            phase_d      = PhRdLow;
            load_idx     = owm_pkg::RegReadLow;
            shift_byte_d = '0;
          end
        endcase
      end
    end else if (phase_cur != PhIdle) begin
      if (slot_timer_q > TimerWidth'(1)) begin
        slot_timer_d = slot_timer_q - TimerWidth'(1);
      end else begin
        slot_timer_d = '0;
        case (phase_cur)
          PhRstLow: begin
            phase_d  = PhRstWait;
            load_en  = 1'b1;
            load_idx = owm_pkg::RegPresenceWait;
          end
          PhRstWait: begin
            presence_d = ~item_i.line_level;
            phase_d    = PhRstTail;
            load_en    = 1'b1;
            load_idx   = owm_pkg::RegResetTail;
          end
          PhRstTail: begin
            phase_d = PhIdle;
            done    = 1'b1;
          end
          PhWrLow: begin
            phase_d  = PhWrHold;
            load_en  = 1'b1;
            load_idx = owm_pkg::RegWriteHold;
          end
          PhWrHold: begin
            shift_byte_d = {1'b0, shift_byte_q[7:1]};
            if (bit_count_q == 3'd7) begin
              phase_d     = PhIdle;
              done        = 1'b1;
              bit_count_d = '0;
            end else begin
              bit_count_d = bit_count_q + 3'd1;
              phase_d     = PhWrLow;
              load_en     = 1'b1;
              load_idx    = owm_pkg::RegWriteLow;
            end
          end
          PhRdLow: begin
            phase_d  = PhRdSamp;
            load_en  = 1'b1;
            load_idx = owm_pkg::RegReadSample;
          end
          PhRdSamp: begin
            shift_byte_d = {item_i.line_level, shift_byte_q[7:1]};
            phase_d      = PhRdTail;
            load_en      = 1'b1;
            load_idx     = owm_pkg::RegReadTail;
          end
          PhRdTail: begin
            if (bit_count_q == 3'd7) begin
              received_d  = shift_byte_q;
              phase_d     = PhIdle;
              done        = 1'b1;
              bit_count_d = '0;
            end else begin
              bit_count_d = bit_count_q + 3'd1;
              phase_d     = PhRdLow;
              load_en     = 1'b1;
              load_idx    = owm_pkg::RegReadLow;
            end
          end
          default: begin
            phase_d = PhIdle;
          end
        endcase
      end
    end

    if (load_en) begin
      slot_timer_d = dur_sat;
    end
  end

  always_comb begin
    case (phase_d)
      PhRstLow, PhWrLow, PhRdLow: drive = 1'b1;
      PhWrHold:                   drive = ~shift_byte_d[0];
      default:                    drive = 1'b0;
    endcase
  end

  assign res_o.drive_low      = drive;
  assign res_o.busy_res       = (phase_d != PhIdle);
  assign res_o.done_res       = done;
  assign res_o.device_present = presence_d;
  assign res_o.read_byte      = received_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhIdle;
      slot_timer_q <= '0;
      bit_count_q  <= '0;
      shift_byte_q <= '0;
      presence_q   <= 1'b0;
      received_q   <= '0;
    end else if (accept_i) begin
      phase_q      <= phase_d;
      slot_timer_q <= slot_timer_d;
      bit_count_q  <= bit_count_d;
      shift_byte_q <= shift_byte_d;
      presence_q   <= presence_d;
      received_q   <= received_d;
    end
  end

  a_phase_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= PhRdTail)
    else $error("phase register holds an unused code");

  a_idle_count_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhIdle) |-> (bit_count_q == 3'd0))
    else $error("bit count left nonzero in idle");

  a_done_releases: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && done) |=> (phase_q == PhIdle && slot_timer_q == '0))
    else $error("completion did not return to idle with a cleared timer");

endmodule
`default_nettype wire

@@ src/owm_out_buf.sv @@
// result register with a skid stage
`timescale 1ns / 1ps
`default_nettype none
module owm_out_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  owm_pkg::out_item_t item_i,
  output logic               ready_o,
  owm_out_if.source          out_o
);

  logic               out_valid_q, skid_valid_q;
  owm_pkg::out_item_t out_q, skid_q;
  logic               pop;

  assign pop     = out_valid_q && out_o.ready;
  assign ready_o = !skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (pop) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end
      end else if (push_i) begin
        if (out_valid_q && !pop) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push_i) begin
      if (out_valid_q && !pop) begin
        skid_q <= item_i;
      end else begin
        out_q <= item_i;
      end
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.item  = out_q;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage holds a beat while the result register is empty");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> !push_i)
    else $error("beat pushed while the skid stage is occupied");

endmodule
`default_nettype wire

@@ src/one_wire_bus_master_top.sv @@
// top level of the 1-wire bus master
//
//   channel  dir  handshake        payload
//   in_i     in   valid / ready    func, line_level, write_byte
//   out_o    out  valid / ready    drive_low, busy_res, done_res, device_present, read_byte
//   cfg_i    in   valid / ready    index (4 bits), data (10 bits)
//
// one beat per clock while ready is high: each input beat updates phase, slot timer
// and shifter in a single pass and is registered in the result register or the skid stage
// a skid stage behind the result register keeps input open for one beat while output stalls
// configuration writes are always taken, indexes beyond the bank are dropped
// async active-low reset restores durations to defaults and returns to idle, no clearing pass
`timescale 1ns / 1ps
`default_nettype none
module one_wire_bus_master_top #(
  parameter int unsigned TimerWidth = owm_pkg::TimerWidth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  owm_in_if.sink    in_i,
  owm_out_if.source out_o,
  owm_cfg_if.sink   cfg_i
);

  owm_pkg::cfg_bank_t regs;
  owm_pkg::out_item_t res;
  logic               buf_ready;
  logic               accept;

  assign in_i.ready = buf_ready;
  assign accept     = in_i.valid && buf_ready;

  owm_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .regs_o (regs)
  );

  owm_core #(
    .TimerWidth (TimerWidth)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_i.item),
    .regs_i   (regs),
    .res_o    (res)
  );

  owm_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .item_i  (res),
    .ready_o (buf_ready),
    .out_o   (out_o)
  );

endmodule
`default_nettype wire
